[rtl/core/rpe_pkg.sv]
// Shared types, constants and the frequency table of the rotary position embedding core.
// Depends on nothing. Every other file under rtl/core uses this package.
`default_nettype none

package rpe_pkg;

  localparam int HEAD_DIM      = 64;
  localparam int MAX_POSITIONS = 2048;
  localparam int THETA_BASE    = 10000;
  localparam int CORDIC_STAGES = 16;

  localparam int DATA_W  = 16;
  localparam int POS_W   = 11;
  localparam int PAIR_W  = 5;
  localparam int ANGLE_W = 32;

  localparam int FREQ_ENTRIES = 1 << PAIR_W;
  localparam int ATAN_ENTRIES = 24;

  // Datapath width of the rotation: 2^14-scaled inputs plus pre-rotation and gain headroom.
  localparam int CORD_W = 33;
  localparam int PROD_W = 64;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_POSITIONS - 1);

  localparam logic [63:0] INV_PI_Q32 = 64'd1367130551;
  localparam logic signed [30:0] GAIN_COMP_Q30 = 31'sd652032874;
  localparam logic signed [PROD_W-1:0] ROUND_HALF_44 = 64'sh0000_0800_0000_0000;

  localparam logic [ANGLE_W-1:0] EIGHTH_TURN = 32'h2000_0000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [ANGLE_W-1:0] freq_tbl_t [FREQ_ENTRIES];
  typedef logic [ANGLE_W-1:0] atan_tbl_t [ATAN_ENTRIES];

  // Arctangent of 2^-k in units of 2^32 per turn.
  localparam atan_tbl_t ATAN_TURNS = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // One item on its way from the front end to the rotator.
  typedef struct packed {
    logic signed [DATA_W-1:0] x_even;
    logic signed [DATA_W-1:0] x_odd;
    logic [ANGLE_W-1:0]       angle;
  } rpe_work_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (b > v) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // theta^(-2i/HEAD_DIM) radians per position, as a 32-bit fraction of a turn.
  function automatic logic [ANGLE_W-1:0] freq_entry(input int unsigned i);
    logic [63:0] t;
    logic [63:0] m;
    logic [63:0] l;
    logic [63:0] e;
    logic [63:0] mant;
    logic [63:0] c;
    logic [63:0] f;
    logic [63:0] n;
    logic [63:0] fq;
    int ip;
    if (HEAD_DIM < 2 || i >= HEAD_DIM / 2 || THETA_BASE < 1) return '0;
    t = 64'(THETA_BASE);
    ip = 0;
    for (int j = 0; j < 63; j++) begin
      if ((t >> (ip + 1)) != 64'd0) ip = ip + 1;
    end
    m = (t << 30) >> ip;
    l = 64'(ip) << 32;
    for (int k = 0; k < 32; k++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        l = l | (64'd1 << (31 - k));
        m = m >> 1;
      end
    end
    e = (l * 64'(2 * i)) / 64'(HEAD_DIM);
    n = e >> 32;
    f = e & 64'h0000_0000_FFFF_FFFF;
    mant = 64'd1 << 31;
    c = isqrt64(64'd1 << 61);
    for (int k = 1; k <= 32; k++) begin
      if (((f >> (32 - k)) & 64'd1) != 64'd0) mant = (mant * c + (64'd1 << 30)) >> 31;
      c = isqrt64(c << 31);
    end
    fq = (n >= 64'd32) ? 64'd0 : (mant >> n);
    return ANGLE_W'((fq * INV_PI_Q32 + (64'd1 << 31)) >> 32);
  endfunction

  function automatic freq_tbl_t build_freq_tbl();
    freq_tbl_t tbl;
    for (int i = 0; i < FREQ_ENTRIES; i++) begin
      tbl[i] = freq_entry(i);
    end
    return tbl;
  endfunction

  localparam freq_tbl_t FREQ_ROM = build_freq_tbl();

endpackage

`default_nettype wire

[rtl/core/rpe_chan_if.sv]
// Valid/ready channel interfaces for element pairs in and rotated pairs out.
// Depends on rpe_pkg for the field widths.
`default_nettype none

interface rpe_pair_if;
  logic                                valid;
  logic                                ready;
  logic signed [rpe_pkg::DATA_W-1:0]   x_even;
  logic signed [rpe_pkg::DATA_W-1:0]   x_odd;
  logic [rpe_pkg::POS_W-1:0]           token_position;
  logic [rpe_pkg::PAIR_W-1:0]          pair_index;

  modport source (output valid, x_even, x_odd, token_position, pair_index, input ready);
  modport sink (input valid, x_even, x_odd, token_position, pair_index, output ready);
endinterface

interface rpe_rot_if;
  logic                                valid;
  logic                                ready;
  logic signed [rpe_pkg::DATA_W-1:0]   y_even;
  logic signed [rpe_pkg::DATA_W-1:0]   y_odd;
  logic                                saturated;

  modport source (output valid, y_even, y_odd, saturated, input ready);
  modport sink (input valid, y_even, y_odd, saturated, output ready);
endinterface

`default_nettype wire

[rtl/core/rpe_front.sv]
// Front end: accepts pairs, looks up the pair frequency and forms the rotation angle.
// Depends on rpe_pkg and rpe_chan_if.
`default_nettype none

module rpe_front (
  input  wire logic              clk,
  input  wire logic              rst,
  rpe_pair_if.sink               pairs,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output rpe_pkg::rpe_work_t     push_data
);

  logic                               adv;
  logic                               s1_vld;
  logic signed [rpe_pkg::DATA_W-1:0]  s1_xe;
  logic signed [rpe_pkg::DATA_W-1:0]  s1_xo;
  logic [rpe_pkg::POS_W-1:0]          s1_pos;
  logic [rpe_pkg::ANGLE_W-1:0]        s1_freq;
  logic [rpe_pkg::POS_W-1:0]          pos_clamped;
  logic [rpe_pkg::POS_W+rpe_pkg::ANGLE_W-1:0] angle_full;

  assign adv         = !push_valid || push_ready;
  assign pairs.ready = adv;

  assign pos_clamped = (32'(pairs.token_position) >= rpe_pkg::MAX_POSITIONS) ?
                       rpe_pkg::POS_LAST : pairs.token_position;

  // The angle wraps modulo one turn, so only the low 32 bits are kept.
  assign angle_full = (rpe_pkg::POS_W + rpe_pkg::ANGLE_W)'(s1_pos) *
                      (rpe_pkg::POS_W + rpe_pkg::ANGLE_W)'(s1_freq);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld     <= 1'b0;
      push_valid <= 1'b0;
    end else if (adv) begin
      s1_vld     <= pairs.valid;
      push_valid <= s1_vld;
    end
    if (adv) begin
      s1_xe            <= pairs.x_even;
      s1_xo            <= pairs.x_odd;
      s1_pos           <= pos_clamped;
      s1_freq          <= rpe_pkg::FREQ_ROM[pairs.pair_index];
      push_data.x_even <= s1_xe;
      push_data.x_odd  <= s1_xo;
      push_data.angle  <= angle_full[rpe_pkg::ANGLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/core/rpe_queue.sv]
// Short first-in first-out queue between the front end and the rotator.
// Depends on rpe_pkg for the item type and depth.
`default_nettype none

module rpe_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire rpe_pkg::rpe_work_t push_data,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output rpe_pkg::rpe_work_t      pop_data
);

  rpe_pkg::rpe_work_t             slots [rpe_pkg::QUEUE_DEPTH];
  logic [rpe_pkg::QPTR_W-1:0]     wr_ptr;
  logic [rpe_pkg::QPTR_W-1:0]     rd_ptr;
  logic [rpe_pkg::QPTR_W:0]       count;
  logic                           push;
  logic                           pop;

  assign push_ready = count != (rpe_pkg::QPTR_W + 1)'(rpe_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

[rtl/core/rpe_back.sv]
// Back end: quadrant pre-rotation, unrolled CORDIC, gain compensation and saturation.
// Depends on rpe_pkg and rpe_chan_if.
`default_nettype none

module rpe_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               pop_valid,
  output logic                    pop_ready,
  input  wire rpe_pkg::rpe_work_t pop_data,
  rpe_rot_if.source               results
);

  localparam int N = rpe_pkg::CORDIC_STAGES;
  localparam int W = rpe_pkg::CORD_W;

  localparam logic [1:0] QUAD_0   = 2'd0;
  localparam logic [1:0] QUAD_90  = 2'd1;
  localparam logic [1:0] QUAD_180 = 2'd2;
  localparam logic [1:0] QUAD_270 = 2'd3;

  logic                 adv;
  logic                 vld [N+2];
  logic signed [W-1:0]  x [N+1];
  logic signed [W-1:0]  y [N+1];
  logic signed [31:0]   z [N+1];
  logic signed [W-1:0]  x_nx [N];
  logic signed [W-1:0]  y_nx [N];
  logic signed [31:0]   z_nx [N];

  logic [31:0]          a2;
  logic signed [W-1:0]  xe_s;
  logic signed [W-1:0]  xo_s;
  logic signed [W-1:0]  x0_nx;
  logic signed [W-1:0]  y0_nx;
  logic signed [31:0]   z0_nx;

  logic signed [rpe_pkg::PROD_W-1:0] prod_e;
  logic signed [rpe_pkg::PROD_W-1:0] prod_o;
  logic signed [rpe_pkg::PROD_W-1:0] sum_e;
  logic signed [rpe_pkg::PROD_W-1:0] sum_o;
  logic signed [19:0]   r_e;
  logic signed [19:0]   r_o;
  logic                 sat_e;
  logic                 sat_o;

  localparam logic signed [19:0] SAT_HI = 20'sd32767;
  localparam logic signed [19:0] SAT_LO = -20'sd32768;

  assign adv       = !results.valid || results.ready;
  assign pop_ready = adv;

  // Inputs scaled by 2^14; the 1/8-turn offset picks the quadrant.
  assign a2   = pop_data.angle + rpe_pkg::EIGHTH_TURN;
  assign xe_s = {{(W - rpe_pkg::DATA_W - 14){pop_data.x_even[rpe_pkg::DATA_W-1]}},
                 pop_data.x_even, 14'd0};
  assign xo_s = {{(W - rpe_pkg::DATA_W - 14){pop_data.x_odd[rpe_pkg::DATA_W-1]}},
                 pop_data.x_odd, 14'd0};
  assign z0_nx = $signed({2'b00, a2[29:0]}) - $signed(rpe_pkg::EIGHTH_TURN);

  always_comb begin
    unique case (a2[31:30])
      QUAD_0: begin
        x0_nx = xe_s;
        y0_nx = xo_s;
      end
      QUAD_90: begin
        x0_nx = -xo_s;
        y0_nx = xe_s;
      end
      QUAD_180: begin
        x0_nx = -xe_s;
        y0_nx = -xo_s;
      end
      QUAD_270: begin
        x0_nx = xo_s;
        y0_nx = -xe_s;
      end
      default: begin
        x0_nx = xe_s;
        y0_nx = xo_s;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (!z[k][31]) begin
        x_nx[k] = x[k] - (y[k] >>> k);
        y_nx[k] = y[k] + (x[k] >>> k);
        z_nx[k] = z[k] - $signed(rpe_pkg::ATAN_TURNS[k]);
      end else begin
        x_nx[k] = x[k] + (y[k] >>> k);
        y_nx[k] = y[k] - (x[k] >>> k);
        z_nx[k] = z[k] + $signed(rpe_pkg::ATAN_TURNS[k]);
      end
    end
  end

  assign sum_e = prod_e + rpe_pkg::ROUND_HALF_44;
  assign sum_o = prod_o + rpe_pkg::ROUND_HALF_44;
  assign r_e   = sum_e[63:44];
  assign r_o   = sum_o[63:44];
  assign sat_e = (r_e > SAT_HI) || (r_e < SAT_LO);
  assign sat_o = (r_o > SAT_HI) || (r_o < SAT_LO);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N + 2; k++) vld[k] <= 1'b0;
      results.valid <= 1'b0;
    end else if (adv) begin
      vld[0] <= pop_valid;
      for (int k = 1; k < N + 2; k++) vld[k] <= vld[k-1];
      results.valid <= vld[N+1];
    end
    if (adv) begin
      x[0] <= x0_nx;
      y[0] <= y0_nx;
      z[0] <= z0_nx;
      for (int k = 0; k < N; k++) begin
        x[k+1] <= x_nx[k];
        y[k+1] <= y_nx[k];
        z[k+1] <= z_nx[k];
      end
      prod_e <= rpe_pkg::PROD_W'(x[N]) * rpe_pkg::PROD_W'(rpe_pkg::GAIN_COMP_Q30);
      prod_o <= rpe_pkg::PROD_W'(y[N]) * rpe_pkg::PROD_W'(rpe_pkg::GAIN_COMP_Q30);
      results.y_even    <= sat_e ? (r_e[19] ? SAT_LO[15:0] : SAT_HI[15:0]) : r_e[15:0];
      results.y_odd     <= sat_o ? (r_o[19] ? SAT_LO[15:0] : SAT_HI[15:0]) : r_o[15:0];
      results.saturated <= sat_e || sat_o;
    end
  end

endmodule

`default_nettype wire

[rtl/core/rotary_position_embedding_core.sv]
// Top level of the rotary position embedding core: front end, queue and CORDIC rotator.
// Depends on rpe_pkg, rpe_chan_if, rpe_front, rpe_queue and rpe_back.
//
//   Channel   Dir  Handshake     Beat contents
//   pairs     in   valid/ready   x_even, x_odd (Q3.12), token_position, pair_index
//   results   out  valid/ready   y_even, y_odd (Q3.12, saturated), saturated
//
// One pair is taken per clock cycle when the output side keeps up. The beat passes 22
// registers, the first loaded at the edge that takes it: the two front-end stages, the
// queue slot, the pre-rotation, sixteen CORDIC stages, the gain multiply and the output
// register of the rotator.
// Reset is synchronous and clears every valid flag, the queue pointers and count only.
// A stall on results freezes the rotator; the queue of four beats lets the front end
// keep accepting until it fills, after which pairs.ready falls.
`default_nettype none

module rotary_position_embedding_core (
  input  wire logic clk,
  input  wire logic rst,
  rpe_pair_if.sink  pairs,
  rpe_rot_if.source results
);

  // Front end to queue.
  logic               fq_valid;
  logic               fq_ready;
  rpe_pkg::rpe_work_t fq_data;

  // Queue to rotator.
  logic               qb_valid;
  logic               qb_ready;
  rpe_pkg::rpe_work_t qb_data;

  // The front end clamps the position, reads the frequency table and forms the angle
  // as position times frequency, wrapping at one turn.
  rpe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pairs      (pairs),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data)
  );

  // The queue decouples the two halves so that a stall on the output does not reach
  // the input at once.
  rpe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // The rotator turns the pair by the angle and rounds the result back to Q3.12.
  rpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_data  (qb_data),
    .results   (results)
  );

endmodule

`default_nettype wire
